FILE: sv/sfr_pkg.sv
// Shared types and constants of the shape fill rasterizer.
// Used by sfr_scan and shape_fill_rasterizer_top; depends on nothing.
`timescale 1ns / 1ps

package sfr_pkg;

  localparam int CoordW = 13;  // cursor and clipped box coordinates
  localparam int CalcW  = 16;  // signed width for box and coverage math
  localparam int AddrW  = 24;
  localparam int ColorW = 32;
  localparam int SqW    = 24;  // square of a clipped delta or of the radius

  typedef logic signed [CalcW-1:0] calc_t;
  typedef logic [CoordW-1:0]       coord_t;

  typedef enum logic {
    KIND_START = 1'b0,
    KIND_STEP  = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    SHAPE_CLEAR   = 3'd0,
    SHAPE_FILL    = 3'd1,
    SHAPE_OUTLINE = 3'd2,
    SHAPE_CIRCLE  = 3'd3,
    SHAPE_ROUNDED = 3'd4
  } shape_e;

  typedef enum logic [2:0] {
    CFG_FILL_COLOR     = 3'd0,
    CFG_ORIGIN_X       = 3'd1,
    CFG_ORIGIN_Y       = 3'd2,
    CFG_RECT_WIDTH     = 3'd3,
    CFG_RECT_HEIGHT    = 3'd4,
    CFG_RADIUS         = 3'd5,
    CFG_SURFACE_WIDTH  = 3'd6,
    CFG_SURFACE_HEIGHT = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [ColorW-1:0] fill_color;
    logic signed [12:0] origin_x;
    logic signed [12:0] origin_y;
    logic [12:0]       rect_width;
    logic [12:0]       rect_height;
    logic [11:0]       radius;
    logic [12:0]       surface_width;
    logic [12:0]       surface_height;
  } cfg_t;

  typedef struct packed {
    logic       kind;
    logic [2:0] shape_select;
  } sfr_in_t;

  typedef struct packed {
    logic              write_enable;
    logic [AddrW-1:0]  pixel_address;
    logic [ColorW-1:0] pixel_data;
    logic              last_pixel;
  } sfr_out_t;

  // One visited position (or a non-pixel result) leaving the scanner
  typedef struct packed {
    logic       visit;
    logic       last;
    logic [2:0] shape;
    coord_t     x;
    coord_t     y;
  } pix_t;

  function automatic calc_t sx13(logic [12:0] v);
    return {{(CalcW-13){v[12]}}, v};
  endfunction

  function automatic calc_t zx13(logic [12:0] v);
    return {{(CalcW-13){1'b0}}, v};
  endfunction

endpackage

FILE: sv/shape_fill_rasterizer_top.sv
// Shape fill rasterizer top: config registers, five-stage pixel pipeline.
// Depends on sfr_pkg and sfr_scan. One request per cycle is sustained while
// the output does not stall; the raster cursor steps once per step request
// and coverage squares sit in a stage of their own.
// Reset empties the pipeline, idles the scanner and restores config defaults.
`timescale 1ns / 1ps

module shape_fill_rasterizer_top #(
  parameter int MAX_SURFACE = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  sfr_pkg::sfr_in_t  in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output sfr_pkg::sfr_out_t out_item_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [2:0]        cfg_index_i,
  input  logic [31:0]       cfg_data_i
);

  localparam int NumStg = 5;

  typedef struct packed {
    logic               visit;
    logic               last;
    sfr_pkg::coord_t    x;
    sfr_pkg::coord_t    y;
    logic               rect_hit;
    logic [3:0]         disc_en;
    logic signed [12:0] dxa;
    logic signed [12:0] dxb;
    logic signed [12:0] dya;
    logic signed [12:0] dyb;
  } s2_t;

  typedef struct packed {
    logic                      visit;
    logic                      last;
    sfr_pkg::coord_t           x;
    logic                      rect_hit;
    logic [3:0]                disc_en;
    logic [sfr_pkg::SqW-1:0]   sq_xa;
    logic [sfr_pkg::SqW-1:0]   sq_xb;
    logic [sfr_pkg::SqW-1:0]   sq_ya;
    logic [sfr_pkg::SqW-1:0]   sq_yb;
    logic [sfr_pkg::SqW-1:0]   r2;
    logic [sfr_pkg::AddrW-1:0] row;
  } s3_t;

  sfr_pkg::cfg_t     cfg_q;
  logic [NumStg-1:0] stg_v_q, stg_v_d, rdy, load;
  sfr_pkg::sfr_in_t  item_q;
  sfr_pkg::pix_t     pix;
  s2_t               s2_q, s2_d;
  s3_t               s3_q, s3_d;
  sfr_pkg::sfr_out_t out_q, out_d;

  // ---------------- configuration ----------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fill_color     <= '0;
      cfg_q.origin_x       <= '0;
      cfg_q.origin_y       <= '0;
      cfg_q.rect_width     <= '0;
      cfg_q.rect_height    <= '0;
      cfg_q.radius         <= '0;
      cfg_q.surface_width  <= 13'd640;
      cfg_q.surface_height <= 13'd480;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (sfr_pkg::cfg_idx_e'(cfg_index_i))
        sfr_pkg::CFG_FILL_COLOR:     cfg_q.fill_color     <= cfg_data_i;
        sfr_pkg::CFG_ORIGIN_X:       cfg_q.origin_x       <= cfg_data_i[12:0];
        sfr_pkg::CFG_ORIGIN_Y:       cfg_q.origin_y       <= cfg_data_i[12:0];
        sfr_pkg::CFG_RECT_WIDTH:     cfg_q.rect_width     <= cfg_data_i[12:0];
        sfr_pkg::CFG_RECT_HEIGHT:    cfg_q.rect_height    <= cfg_data_i[12:0];
        sfr_pkg::CFG_RADIUS:         cfg_q.radius         <= cfg_data_i[11:0];
        sfr_pkg::CFG_SURFACE_WIDTH:  cfg_q.surface_width  <= cfg_data_i[12:0];
        sfr_pkg::CFG_SURFACE_HEIGHT: cfg_q.surface_height <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  // ---------------- pipeline flow control ----------------
  // A stage takes new data when it is empty or its content moves on.
  always_comb begin
    rdy[NumStg-1] = !stg_v_q[NumStg-1] || !out_stall_i;
    for (int k = NumStg-2; k >= 0; k--) begin
      rdy[k] = !stg_v_q[k] || rdy[k+1];
    end
    load[0] = in_valid_i && rdy[0];
    for (int k = 1; k < NumStg; k++) begin
      load[k] = stg_v_q[k-1] && rdy[k];
    end
    for (int k = 0; k < NumStg-1; k++) begin
      stg_v_d[k] = load[k] || (stg_v_q[k] && !rdy[k+1]);
    end
    stg_v_d[NumStg-1] = load[NumStg-1] || (stg_v_q[NumStg-1] && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_v_q <= '0;
    end else begin
      stg_v_q <= stg_v_d;
    end
  end

  assign in_stall_o = !rdy[0];

  // ---------------- stage 0: request register ----------------
  always_ff @(posedge clk_i) begin
    if (load[0]) item_q <= in_item_i;
  end

  // ---------------- stage 1: box latch and cursor ----------------
  sfr_scan #(
    .MaxSurface(MAX_SURFACE)
  ) u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (load[1]),
    .item_i (item_q),
    .cfg_i  (cfg_q),
    .pix_o  (pix)
  );

  // ---------------- stage 2: span tests and disc deltas ----------------
  always_comb begin
    sfr_pkg::calc_t ox, oy, w, h, r, xs, ys;
    sfr_pkg::calc_t cxa, cxb, cya, cyb, dxa, dxb, dya, dyb;
    logic in_x, in_y, rim_hit, bar_a, bar_b;
    logic rxa, rxb, rya, ryb;

    ox = sfr_pkg::sx13(cfg_q.origin_x);
    oy = sfr_pkg::sx13(cfg_q.origin_y);
    w  = sfr_pkg::zx13(cfg_q.rect_width);
    h  = sfr_pkg::zx13(cfg_q.rect_height);
    r  = sfr_pkg::zx13({1'b0, cfg_q.radius});
    xs = sfr_pkg::zx13(pix.x);
    ys = sfr_pkg::zx13(pix.y);

    in_x    = (xs >= ox) && (xs < ox + w);
    in_y    = (ys >= oy) && (ys < oy + h);
    rim_hit = (xs == ox) || (ys == oy) ||
              (xs == ox + w - sfr_pkg::calc_t'(1)) || (ys == oy + h - sfr_pkg::calc_t'(1));
    bar_a   = in_x && (ys >= oy + r) && (ys < oy + h - r);
    bar_b   = in_y && (xs >= ox + r) && (xs < ox + w - r);

    // a plain circle uses only the first center
    cxa = (pix.shape == sfr_pkg::SHAPE_CIRCLE) ? ox : ox + r;
    cya = (pix.shape == sfr_pkg::SHAPE_CIRCLE) ? oy : oy + r;
    cxb = ox + w - r;
    cyb = oy + h - r;
    dxa = xs - cxa;
    dxb = xs - cxb;
    dya = ys - cya;
    dyb = ys - cyb;
    rxa = (dxa >= -r) && (dxa < r);
    rxb = (dxb >= -r) && (dxb < r);
    rya = (dya >= -r) && (dya < r);
    ryb = (dyb >= -r) && (dyb < r);

    s2_d.visit    = pix.visit;
    s2_d.last     = pix.last;
    s2_d.x        = pix.x;
    s2_d.y        = pix.y;
    s2_d.rect_hit = 1'b0;
    s2_d.disc_en  = '0;
    case (pix.shape)
      sfr_pkg::SHAPE_CLEAR:   s2_d.rect_hit = 1'b1;
      sfr_pkg::SHAPE_FILL:    s2_d.rect_hit = in_x && in_y;
      sfr_pkg::SHAPE_OUTLINE: s2_d.rect_hit = in_x && in_y && rim_hit;
      sfr_pkg::SHAPE_CIRCLE:  s2_d.disc_en  = {3'b000, rxa && rya};
      sfr_pkg::SHAPE_ROUNDED: begin
        s2_d.rect_hit = bar_a || bar_b;
        s2_d.disc_en  = {rxb && ryb, rxa && ryb, rxb && rya, rxa && rya};
      end
      default: ;
    endcase
    // deltas fit 13 bits whenever their disc is enabled
    s2_d.dxa = dxa[12:0];
    s2_d.dxb = dxb[12:0];
    s2_d.dya = dya[12:0];
    s2_d.dyb = dyb[12:0];
  end

  always_ff @(posedge clk_i) begin
    if (load[2]) s2_q <= s2_d;
  end

  // ---------------- stage 3: squares and row base ----------------
  always_comb begin
    logic signed [12:0]      a, b, c, d;
    logic signed [25:0]      pa, pb, pc, pd;
    logic [sfr_pkg::SqW-1:0] rr;
    logic [25:0]             prow;

    a  = s2_q.dxa;
    b  = s2_q.dxb;
    c  = s2_q.dya;
    d  = s2_q.dyb;
    pa = 26'(a) * 26'(a);
    pb = 26'(b) * 26'(b);
    pc = 26'(c) * 26'(c);
    pd = 26'(d) * 26'(d);
    rr = {{(sfr_pkg::SqW-12){1'b0}}, cfg_q.radius};
    prow = 26'(s2_q.y) * 26'(cfg_q.surface_width);

    s3_d.visit    = s2_q.visit;
    s3_d.last     = s2_q.last;
    s3_d.x        = s2_q.x;
    s3_d.rect_hit = s2_q.rect_hit;
    s3_d.disc_en  = s2_q.disc_en;
    s3_d.sq_xa    = pa[sfr_pkg::SqW-1:0];
    s3_d.sq_xb    = pb[sfr_pkg::SqW-1:0];
    s3_d.sq_ya    = pc[sfr_pkg::SqW-1:0];
    s3_d.sq_yb    = pd[sfr_pkg::SqW-1:0];
    s3_d.r2       = rr * rr;
    s3_d.row      = prow[sfr_pkg::AddrW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (load[3]) s3_q <= s3_d;
  end

  // ---------------- stage 4: coverage decision and result ----------------
  always_comb begin
    logic [sfr_pkg::SqW:0] sum0, sum1, sum2, sum3, lim;
    logic hit, we;

    sum0 = {1'b0, s3_q.sq_xa} + {1'b0, s3_q.sq_ya};
    sum1 = {1'b0, s3_q.sq_xb} + {1'b0, s3_q.sq_ya};
    sum2 = {1'b0, s3_q.sq_xa} + {1'b0, s3_q.sq_yb};
    sum3 = {1'b0, s3_q.sq_xb} + {1'b0, s3_q.sq_yb};
    lim  = {1'b0, s3_q.r2};
    hit  = s3_q.rect_hit ||
           (s3_q.disc_en[0] && (sum0 <= lim)) ||
           (s3_q.disc_en[1] && (sum1 <= lim)) ||
           (s3_q.disc_en[2] && (sum2 <= lim)) ||
           (s3_q.disc_en[3] && (sum3 <= lim));
    we   = s3_q.visit && hit;

    out_d.write_enable  = we;
    out_d.pixel_address = s3_q.visit ? s3_q.row + sfr_pkg::AddrW'(s3_q.x) : '0;
    out_d.pixel_data    = we ? cfg_q.fill_color : '0;
    out_d.last_pixel    = s3_q.last;
  end

  always_ff @(posedge clk_i) begin
    if (load[4]) out_q <= out_d;
  end

  assign out_valid_o = stg_v_q[NumStg-1];
  assign out_item_o  = out_q;

  // ---------------- assertions ----------------
  // back-pressure reaches the input only with every stage occupied
  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> ((&stg_v_q) && out_stall_i))
    else $error("input stalled while the pipeline has a free stage");

  // a taken result with nothing behind it leaves the output empty
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !stg_v_q[NumStg-2]) |=> !out_valid_o)
    else $error("result repeated after it was taken");

endmodule

FILE: sv/sfr_scan.sv
// Bounding box latch and raster cursor of the shape fill rasterizer.
// Depends on sfr_pkg.
`timescale 1ns / 1ps

module sfr_scan #(
  parameter int MaxSurface = 4096
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  sfr_pkg::sfr_in_t item_i,
  input  sfr_pkg::cfg_t   cfg_i,
  output sfr_pkg::pix_t   pix_o
);

  sfr_pkg::coord_t cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  sfr_pkg::coord_t bx0_q, bx0_d, by0_q, by0_d, bx1_q, bx1_d, by1_q, by1_d;
  logic [2:0]      shape_q, shape_d;
  logic            busy_q, busy_d;
  sfr_pkg::pix_t   pix_q, pix_d;

  always_comb begin
    sfr_pkg::calc_t ox, oy, w, h, r, lx, ly;
    sfr_pkg::calc_t x0, y0, x1, y1, ax, bx, ay, by;
    sfr_pkg::calc_t cx0, cy0, cx1, cy1;
    sfr_pkg::coord_t lim_x, lim_y;
    logic [sfr_pkg::CoordW:0] nx;
    logic last;

    ox = sfr_pkg::sx13(cfg_i.origin_x);
    oy = sfr_pkg::sx13(cfg_i.origin_y);
    w  = sfr_pkg::zx13(cfg_i.rect_width);
    h  = sfr_pkg::zx13(cfg_i.rect_height);
    r  = sfr_pkg::zx13({1'b0, cfg_i.radius});
    lim_x = (int'(cfg_i.surface_width) < MaxSurface) ? cfg_i.surface_width
                                                     : sfr_pkg::CoordW'(MaxSurface);
    lim_y = (int'(cfg_i.surface_height) < MaxSurface) ? cfg_i.surface_height
                                                      : sfr_pkg::CoordW'(MaxSurface);
    lx = sfr_pkg::zx13(lim_x);
    ly = sfr_pkg::zx13(lim_y);

    x0 = '0; y0 = '0; x1 = '0; y1 = '0;
    ax = ox + w - (r <<< 1);
    bx = ox + (r <<< 1);
    ay = oy + h - (r <<< 1);
    by = oy + (r <<< 1);
    cx0 = '0; cy0 = '0; cx1 = '0; cy1 = '0;
    nx = '0;
    last = 1'b0;

    cur_x_d = cur_x_q;
    cur_y_d = cur_y_q;
    bx0_d   = bx0_q;
    by0_d   = by0_q;
    bx1_d   = bx1_q;
    by1_d   = by1_q;
    shape_d = shape_q;
    busy_d  = busy_q;
    pix_d   = pix_q;

    if (item_i.kind == sfr_pkg::KIND_START) begin
      case (item_i.shape_select) inside
        sfr_pkg::SHAPE_CLEAR: begin
          x1 = lx;
          y1 = ly;
        end
        sfr_pkg::SHAPE_FILL, sfr_pkg::SHAPE_OUTLINE: begin
          x0 = ox;
          y0 = oy;
          x1 = ox + w;
          y1 = oy + h;
        end
        sfr_pkg::SHAPE_CIRCLE: begin
          x0 = ox - r;
          y0 = oy - r;
          x1 = ox + r;
          y1 = oy + r;
        end
        sfr_pkg::SHAPE_ROUNDED: begin
          x0 = ox;
          y0 = oy;
          x1 = ox + w;
          y1 = oy + h;
          // corner discs may reach past the rectangle when the radius is large
          if (r > 0) begin
            if (ax < x0) x0 = ax;
            if (bx > x1) x1 = bx;
            if (ay < y0) y0 = ay;
            if (by > y1) y1 = by;
          end
        end
        default: ;
      endcase

      cx0 = (x0 < 0) ? '0 : x0;
      cy0 = (y0 < 0) ? '0 : y0;
      cx1 = (x1 < lx) ? x1 : lx;
      cy1 = (y1 < ly) ? y1 : ly;

      busy_d  = (cx0 < cx1) && (cy0 < cy1);
      bx0_d   = cx0[sfr_pkg::CoordW-1:0];
      by0_d   = cy0[sfr_pkg::CoordW-1:0];
      bx1_d   = cx1[sfr_pkg::CoordW-1:0];
      by1_d   = cy1[sfr_pkg::CoordW-1:0];
      cur_x_d = cx0[sfr_pkg::CoordW-1:0];
      cur_y_d = cy0[sfr_pkg::CoordW-1:0];
      shape_d = item_i.shape_select;

      pix_d.visit = 1'b0;
      pix_d.last  = !busy_d;
      pix_d.shape = item_i.shape_select;
      pix_d.x     = '0;
      pix_d.y     = '0;
    end else if (busy_q) begin
      last = (cur_x_q == bx1_q - sfr_pkg::coord_t'(1)) &&
             (cur_y_q == by1_q - sfr_pkg::coord_t'(1));
      nx = {1'b0, cur_x_q} + (sfr_pkg::CoordW+1)'(1);

      pix_d.visit = 1'b1;
      pix_d.last  = last;
      pix_d.shape = shape_q;
      pix_d.x     = cur_x_q;
      pix_d.y     = cur_y_q;

      if (last) begin
        busy_d = 1'b0;
      end else if (nx >= {1'b0, bx1_q}) begin
        cur_x_d = bx0_q;
        cur_y_d = cur_y_q + sfr_pkg::coord_t'(1);
      end else begin
        cur_x_d = nx[sfr_pkg::CoordW-1:0];
      end
    end else begin
      pix_d.visit = 1'b0;
      pix_d.last  = 1'b1;
      pix_d.shape = shape_q;
      pix_d.x     = '0;
      pix_d.y     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q <= '0;
      cur_y_q <= '0;
      bx0_q   <= '0;
      by0_q   <= '0;
      bx1_q   <= '0;
      by1_q   <= '0;
      shape_q <= '0;
      busy_q  <= 1'b0;
      pix_q   <= '0;
    end else if (load_i) begin
      cur_x_q <= cur_x_d;
      cur_y_q <= cur_y_d;
      bx0_q   <= bx0_d;
      by0_q   <= by0_d;
      bx1_q   <= bx1_d;
      by1_q   <= by1_d;
      shape_q <= shape_d;
      busy_q  <= busy_d;
      pix_q   <= pix_d;
    end
  end

  assign pix_o = pix_q;

endmodule
